// ===== sv/rpit_pkg.sv =====
// shared types and constants of the recurrence valuation test
// no dependencies; used by the channel interfaces and the top level
`default_nettype none
package rpit_pkg;

  // payload widths
  localparam int COEF_W    = 21;
  localparam int PRIME_W   = 8;
  localparam int TERM_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  // datapath widths
  localparam int ACC_W  = 40;   // signed polynomial value
  localparam int NN_W   = 16;   // n squared, n below 254
  localparam int MULB_W = 64;   // multiplier operand walked one bit per step
  localparam int CNT_W  = 6;    // bit counter of the serial units
  localparam int VAL_W  = 9;    // valuation counts

  // parameter defaults
  localparam int MOD_WIDTH_DEF = 64;
  localparam int MAX_TERMS_DEF = 254;

  // register reset values
  localparam logic [PRIME_W-1:0]   PRIME_RESET = 8'd2;
  localparam logic [CFG_DAT_W-1:0] MOD_RESET   = 64'h4000_0000_0000_0000;
  localparam logic [TERM_W-1:0]    TERM_RESET  = 8'd32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMS   = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_A1,
    S_A1X,
    S_PN0,
    S_PN1,
    S_PN2,
    S_PNX,
    S_QN0,
    S_QN1,
    S_QN2,
    S_QNX,
    S_RN,
    S_RNX,
    S_T3X,
    S_T2X,
    S_T1X,
    S_VN,
    S_VN_CHK,
    S_VA,
    S_VA_CHK,
    S_NEXT,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/rpit_if.sv =====
// valid/ready channel interfaces: input item, result item, register writes
// depends on rpit_pkg
`default_nettype none
interface rpit_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rpit_pkg::COEF_W-1:0]      alpha;
  logic signed [rpit_pkg::COEF_W-1:0]      beta;
  logic signed [rpit_pkg::COEF_W-1:0]      gamma;
  logic signed [rpit_pkg::COEF_W-1:0]      delta;
  logic signed [rpit_pkg::COEF_W-1:0]      epsilon;
  logic signed [rpit_pkg::COEF_W-1:0]      zeta;
  modport source (output valid, alpha, beta, gamma, delta, epsilon, zeta, input ready);
  modport sink   (input valid, alpha, beta, gamma, delta, epsilon, zeta, output ready);
endinterface

interface rpit_out_if;
  logic valid;
  logic ready;
  logic passes;
  modport source (output valid, passes, input ready);
  modport sink   (input valid, passes, output ready);
endinterface

interface rpit_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rpit_pkg::CFG_IDX_W-1:0]    index;
  logic [rpit_pkg::CFG_DAT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/recurrence_padic_integrality_test.sv =====
// p-adic valuation test of a scaled three-term recurrence, one candidate per item
// a shared shift-add modular multiplier (a doubling step and an add step per operand bit
// over 64 bits) and a bit-serial divider by p serve the whole item, so the block takes
// one item at a time; the next item is taken once the result has been taken
// reset (synchronous, rst_n low): idle, no result pending, registers to 2, 2^62, 32
`default_nettype none
module recurrence_padic_integrality_test #(
  parameter int MOD_WIDTH = rpit_pkg::MOD_WIDTH_DEF,
  parameter int MAX_TERMS = rpit_pkg::MAX_TERMS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rpit_in_if.sink    in_ch,
  rpit_out_if.source out_ch,
  rpit_cfg_if.sink   cfg_ch
);
  import rpit_pkg::*;

  localparam int W = MOD_WIDTH;

  state_t state_r, state_nxt, ret_r;

  // configuration
  logic [PRIME_W-1:0] prime_r;
  logic [W-1:0]       mod_r;
  logic [TERM_W-1:0]  term_r;

  // item and recurrence state
  logic signed [COEF_W-1:0] alpha_r, beta_r, gamma_r, delta_r, epsilon_r, zeta_r;
  logic [TERM_W-1:0]        nmax_r, n_r;
  logic [NN_W-1:0]          nn_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [W-1:0]             rp_r, rq_r, t2_r, a0_r, a1_r, a2_r;
  logic [PRIME_W-1:0]       fv_r;
  logic [VAL_W-1:0]         need_r, vcnt_r;
  logic                     ok_r;

  // shared modular multiplier
  logic [W-1:0]       mr_r, ma_r;
  logic [MULB_W-1:0]  mb_r;
  logic               phase_r;
  logic [CNT_W-1:0]   cnt_r;

  // serial divider by p
  logic [W-1:0]       dx_r;
  logic [PRIME_W-1:0] rem_r;

  // result register
  logic out_valid_r, out_pass_r;

  logic in_acc, cfg_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  // saturated term count of a new item
  logic [TERM_W-1:0] nmax_in;
  assign nmax_in = (32'(term_r) > MAX_TERMS) ? TERM_W'(MAX_TERMS) : term_r;

  // coefficient multiplier for the polynomial values
  logic signed [COEF_W-1:0]   pm_a;
  logic signed [NN_W+1:0]     pm_b;
  logic signed [COEF_W+NN_W+1:0] pm_prod;
  logic signed [ACC_W-1:0]    prod_ext, cst_ext;
  always_comb begin
    pm_a = alpha_r;
    pm_b = signed'({2'b00, nn_r});
    case (state_r)
      S_PN1:   begin pm_a = beta_r;    pm_b = signed'({10'd0, n_r}); end
      S_QN0:   begin pm_a = delta_r;   pm_b = signed'({2'b00, nn_r}); end
      S_QN1:   begin pm_a = epsilon_r; pm_b = signed'({10'd0, n_r}); end
      default: begin pm_a = alpha_r;   pm_b = signed'({2'b00, nn_r}); end
    endcase
  end
  assign pm_prod  = pm_a * pm_b;
  assign prod_ext = {pm_prod[COEF_W+NN_W+1], pm_prod};
  assign cst_ext  = (state_r == S_QN0) ? {{(ACC_W-COEF_W){zeta_r[COEF_W-1]}}, zeta_r}
                                       : {{(ACC_W-COEF_W){gamma_r[COEF_W-1]}}, gamma_r};

  // magnitudes for reduction
  logic [ACC_W-1:0]  acc_mag;
  logic [COEF_W:0]   ga_mag;
  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign ga_mag  = gamma_r[COEF_W-1] ? (COEF_W+1)'(-{gamma_r[COEF_W-1], gamma_r})
                                     : {1'b0, gamma_r};

  // modular adder of the multiplier: doubling step, then add step
  logic [W-1:0] ad_y, ad_res;
  logic [W:0]   ad_sum;
  assign ad_y   = phase_r ? (mb_r[MULB_W-1] ? ma_r : '0) : mr_r;
  assign ad_sum = {1'b0, mr_r} + {1'b0, ad_y};
  assign ad_res = (ad_sum >= {1'b0, mod_r}) ? W'(ad_sum - {1'b0, mod_r}) : W'(ad_sum);
  logic mul_last;
  assign mul_last = phase_r && (cnt_r == CNT_W'(MULB_W - 1));

  // sign fix of a reduced magnitude
  logic [W-1:0] red_fix;
  assign red_fix = (neg_r && (mr_r != '0)) ? (mod_r - mr_r) : mr_r;

  // subtraction of the two recurrence products
  logic [W:0]   sb_diff;
  logic [W-1:0] sb_res;
  assign sb_diff = {1'b0, mr_r} - {1'b0, t2_r};
  assign sb_res  = sb_diff[W] ? W'(sb_diff + {1'b0, mod_r}) : W'(sb_diff);

  // divider step
  logic [PRIME_W:0]   dv_s;
  logic               dv_ge;
  logic [PRIME_W-1:0] dv_rem;
  assign dv_s   = {rem_r, dx_r[W-1]};
  assign dv_ge  = dv_s >= {1'b0, prime_r};
  assign dv_rem = dv_ge ? PRIME_W'(dv_s - {1'b0, prime_r}) : PRIME_W'(dv_s);
  logic div_last;
  assign div_last = (cnt_r == CNT_W'(W - 1));

  logic [VAL_W-1:0]  vcnt_inc;
  logic [TERM_W-1:0] n_inc;
  logic              last_term;
  assign vcnt_inc  = vcnt_r + VAL_W'(1);
  assign n_inc     = n_r + TERM_W'(1);
  assign last_term = ({1'b0, n_r} + 9'd2) > {1'b0, nmax_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((mod_r < W'(2)) || (prime_r < PRIME_W'(2)) || (nmax_in < TERM_W'(2)))
            state_nxt = S_DONE;
          else
            state_nxt = S_A1;
        end
      end
      S_A1:     state_nxt = S_MUL;
      S_A1X:    state_nxt = S_PN0;
      S_PN0:    state_nxt = S_PN1;
      S_PN1:    state_nxt = S_PN2;
      S_PN2:    state_nxt = S_MUL;
      S_PNX:    state_nxt = S_QN0;
      S_QN0:    state_nxt = S_QN1;
      S_QN1:    state_nxt = S_QN2;
      S_QN2:    state_nxt = S_MUL;
      S_QNX:    state_nxt = S_RN;
      S_RN:     state_nxt = S_MUL;
      S_RNX:    state_nxt = S_MUL;
      S_T3X:    state_nxt = S_MUL;
      S_T2X:    state_nxt = S_MUL;
      S_T1X:    state_nxt = S_VN;
      S_VN:     state_nxt = S_DIV;
      S_VN_CHK: state_nxt = (rem_r == '0) ? S_DIV : S_VA;
      S_VA:     state_nxt = ((need_r == '0) || (a2_r == '0)) ? S_NEXT : S_DIV;
      S_VA_CHK: begin
        if (rem_r != '0)
          state_nxt = S_DONE;
        else if (vcnt_inc >= need_r)
          state_nxt = S_NEXT;
        else
          state_nxt = S_DIV;
      end
      S_NEXT:   state_nxt = last_term ? S_DONE : S_PN0;
      S_MUL:    state_nxt = mul_last ? ret_r : S_MUL;
      S_DIV:    state_nxt = div_last ? ret_r : S_DIV;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    in_ch.ready   = (state_r == S_IDLE) && !out_valid_r;
    cfg_ch.ready  = 1'b1;
    out_ch.valid  = out_valid_r;
    out_ch.passes = out_pass_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prime_r     <= PRIME_RESET;
      mod_r       <= MOD_RESET[W-1:0];
      term_r      <= TERM_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
      if (cfg_acc) begin
        case (cfg_ch.index)
          CFG_PRIME:   prime_r <= cfg_ch.data[PRIME_W-1:0];
          CFG_MODULUS: mod_r   <= cfg_ch.data[W-1:0];
          CFG_TERMS:   term_r  <= cfg_ch.data[TERM_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          alpha_r   <= in_ch.alpha;
          beta_r    <= in_ch.beta;
          gamma_r   <= in_ch.gamma;
          delta_r   <= in_ch.delta;
          epsilon_r <= in_ch.epsilon;
          zeta_r    <= in_ch.zeta;
          nmax_r    <= nmax_in;
          n_r       <= TERM_W'(1);
          nn_r      <= NN_W'(1);
          a0_r      <= W'(1);
          fv_r      <= '0;
          ok_r      <= 1'b1;
        end
      end
      // reduce gamma into the first term
      S_A1: begin
        neg_r   <= gamma_r[COEF_W-1];
        mr_r    <= '0;
        ma_r    <= W'(1);
        mb_r    <= MULB_W'(ga_mag);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= S_A1X;
      end
      S_A1X: a1_r <= red_fix;
      // P(n) and Q(n)
      S_PN0, S_QN0: acc_r <= prod_ext + cst_ext;
      S_PN1, S_QN1: acc_r <= acc_r + prod_ext;
      S_PN2, S_QN2: begin
        neg_r   <= acc_r[ACC_W-1];
        mr_r    <= '0;
        ma_r    <= W'(1);
        mb_r    <= MULB_W'(acc_mag);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= (state_r == S_PN2) ? S_PNX : S_QNX;
      end
      S_PNX: rp_r <= red_fix;
      S_QNX: rq_r <= red_fix;
      // n squared mod m
      S_RN: begin
        neg_r   <= 1'b0;
        mr_r    <= '0;
        ma_r    <= W'(1);
        mb_r    <= MULB_W'(nn_r);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= S_RNX;
      end
      // chain of modular products
      S_RNX: begin
        mr_r    <= '0;
        ma_r    <= mr_r;
        mb_r    <= MULB_W'(rq_r);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= S_T3X;
      end
      S_T3X: begin
        mr_r    <= '0;
        ma_r    <= mr_r;
        mb_r    <= MULB_W'(a0_r);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= S_T2X;
      end
      S_T2X: begin
        t2_r    <= mr_r;
        mr_r    <= '0;
        ma_r    <= rp_r;
        mb_r    <= MULB_W'(a1_r);
        cnt_r   <= '0;
        phase_r <= 1'b0;
        ret_r   <= S_T1X;
      end
      S_T1X: a2_r <= sb_res;
      // valuation of n+1 added to the factorial valuation
      S_VN: begin
        dx_r  <= W'(n_inc);
        rem_r <= '0;
        cnt_r <= '0;
        ret_r <= S_VN_CHK;
      end
      S_VN_CHK: begin
        if (rem_r == '0) begin
          fv_r  <= fv_r + PRIME_W'(1);
          cnt_r <= '0;
          ret_r <= S_VN_CHK;
        end else begin
          need_r <= {fv_r, 1'b0};
        end
      end
      // divide the new term by p up to the bound
      S_VA: begin
        dx_r   <= a2_r;
        rem_r  <= '0;
        cnt_r  <= '0;
        vcnt_r <= '0;
        ret_r  <= S_VA_CHK;
      end
      S_VA_CHK: begin
        if (rem_r != '0) begin
          ok_r <= 1'b0;
        end else begin
          vcnt_r <= vcnt_inc;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end
      S_NEXT: begin
        a0_r <= a1_r;
        a1_r <= a2_r;
        n_r  <= n_inc;
        nn_r <= NN_W'(n_inc) * NN_W'(n_inc);
      end
      // shift-add multiply, a doubling phase and an add phase per bit of the b operand
      S_MUL: begin
        mr_r    <= ad_res;
        phase_r <= !phase_r;
        if (phase_r) begin
          mb_r  <= {mb_r[MULB_W-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      // restoring division by p, one bit per cycle
      S_DIV: begin
        dx_r  <= {dx_r[W-2:0], dv_ge};
        rem_r <= dv_rem;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      S_DONE: out_pass_r <= ok_r;
      default: ;
    endcase
  end

  // checks
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == S_IDLE))
    else $error("item accepted while busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_mul_residue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (mr_r < mod_r))
    else $error("partial product not reduced");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < prime_r))
    else $error("divider remainder not below p");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench of the recurrence valuation test: directed register settings, special cases,
// then random candidates under varying idle and stall pressure; depends on rpit_pkg, rpit_if
`timescale 1ns / 100ps
module tb;
  import rpit_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int MAX_TERM_SAT = 254;
  localparam int STALL_LIMIT = 10000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [COEF_W-1:0] alpha;
    logic signed [COEF_W-1:0] beta;
    logic signed [COEF_W-1:0] gamma;
    logic signed [COEF_W-1:0] delta;
    logic signed [COEF_W-1:0] epsilon;
    logic signed [COEF_W-1:0] zeta;
  } coef_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rpit_in_if  in_ch ();
  rpit_out_if out_ch ();
  rpit_cfg_if cfg_ch ();

  recurrence_padic_integrality_test uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the registers
  logic [PRIME_W-1:0]   cur_prime = PRIME_RESET;
  logic [CFG_DAT_W-1:0] cur_mod   = MOD_RESET;
  logic [TERM_W-1:0]    cur_terms = TERM_RESET;

  bit   expected_passes[$];
  int   failures  = 0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  bit   in_up  = 0;
  bit   cfg_up = 0;

  always #HALF_PERIOD clk = ~clk;

  // modular helpers, operands below m
  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    if (a >= m - b) return a - (m - b);
    return a + b;
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  function automatic logic [63:0] wrap_mod(longint x, logic [63:0] m);
    logic [63:0] mag;
    if (x >= 0) return 64'(x) % m;
    mag = (64'd0 - 64'(x)) % m;
    return (mag == 0) ? 64'd0 : m - mag;
  endfunction

  // valuation of k! at base p
  function automatic int unsigned fact_exp(int unsigned k, int unsigned p);
    int unsigned s;
    int unsigned q;
    s = 0;
    q = p;
    while (q <= k) begin
      s += k / q;
      if (q > k / p) break;
      q *= p;
    end
    return s;
  endfunction

  // runs the recurrence and checks each new term against its valuation bound
  function automatic bit predict_passes(coef_set_t c);
    longint al, be, ga, de, ep, ze, nn, pn, qn;
    logic [63:0] m, a0, a1, a2, t1, t2, x;
    int unsigned p, nmax, need, v;
    al = c.alpha; be = c.beta; ga = c.gamma;
    de = c.delta; ep = c.epsilon; ze = c.zeta;
    m = cur_mod;
    p = cur_prime;
    nmax = cur_terms;
    if (nmax > MAX_TERM_SAT) nmax = MAX_TERM_SAT;
    if (m < 2 || p < 2) return 1'b1;
    a0 = 64'd1;
    a1 = wrap_mod(ga, m);
    for (int unsigned n = 1; n + 1 <= nmax; n++) begin
      nn = longint'(n) * longint'(n);
      pn = al * nn + be * longint'(n) + ga;
      qn = de * nn + ep * longint'(n) + ze;
      t1 = mul_mod(wrap_mod(pn, m), a1, m);
      t2 = mul_mod(mul_mod(64'(nn) % m, wrap_mod(qn, m), m), a0, m);
      a2 = (t1 >= t2) ? t1 - t2 : t1 + (m - t2);
      need = 2 * fact_exp(n + 1, p);
      if (need > 0 && a2 != 0) begin
        x = a2;
        v = 0;
        while (v < need && x % p == 0) begin
          x = x / p;
          v++;
        end
        if (v < need) return 1'b0;
      end
      a0 = a1;
      a1 = a2;
    end
    return 1'b1;
  endfunction

  task automatic lower_in();
    if (in_up) begin
      in_ch.valid <= 1'b0;
      in_up = 0;
    end
  endtask

  task automatic lower_cfg();
    if (cfg_up) begin
      cfg_ch.valid <= 1'b0;
      cfg_up = 0;
    end
  endtask

  // send one item, with a random gap first
  task automatic send_item(coef_set_t c);
    lower_cfg();
    if ($urandom_range(99) < idle_pct) begin
      lower_in();
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.alpha   <= c.alpha;
    in_ch.beta    <= c.beta;
    in_ch.gamma   <= c.gamma;
    in_ch.delta   <= c.delta;
    in_ch.epsilon <= c.epsilon;
    in_ch.zeta    <= c.zeta;
    in_up = 1;
    do @(posedge clk); while (!in_ch.ready);
    expected_passes.push_back(predict_passes(c));
  endtask

  task automatic wait_drain();
    lower_in();
    lower_cfg();
    while (expected_passes.size() != 0) @(posedge clk);
  endtask

  // register write, only with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    lower_in();
    while (expected_passes.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_up = 1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_PRIME:   cur_prime = data[PRIME_W-1:0];
      CFG_MODULUS: cur_mod = data;
      CFG_TERMS:   cur_terms = data[TERM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [7:0] p, logic [63:0] m, logic [7:0] n);
    write_reg(CFG_PRIME, 64'(p));
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_TERMS, 64'(n));
  endtask

  function automatic coef_set_t same_coefs(logic signed [COEF_W-1:0] v);
    coef_set_t c;
    c.alpha = v; c.beta = v; c.gamma = v; c.delta = v; c.epsilon = v; c.zeta = v;
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    if (sel < 40) return COEF_W'($signed($urandom_range(6)) - 3);
    if (sel < 45) return {1'b1, {(COEF_W-1){1'b0}}};
    if (sel < 50) return {1'b0, {(COEF_W-1){1'b1}}};
    return COEF_W'($urandom);
  endfunction

  function automatic coef_set_t rand_coefs();
    coef_set_t c;
    c.alpha = rand_coef(); c.beta = rand_coef(); c.gamma = rand_coef();
    c.delta = rand_coef(); c.epsilon = rand_coef(); c.zeta = rand_coef();
    return c;
  endfunction

  // largest power of p not above 2^64-1, at most k factors
  function automatic logic [63:0] prime_power(int unsigned p, int unsigned k);
    logic [63:0] m;
    m = 64'd1;
    for (int unsigned i = 0; i < k; i++) begin
      if (m > 64'hFFFF_FFFF_FFFF_FFFF / p) break;
      m = m * p;
    end
    return m;
  endfunction

  // register reset values and field extremes
  task automatic test_reset_values();
    coef_set_t c;
    send_item(same_coefs('0));
    c = same_coefs({1'b0, {(COEF_W-1){1'b1}}});
    send_item(c);
    set_regs(8'd3, prime_power(3, 40), 8'd4);
    send_item(c);
    send_item(same_coefs({1'b1, {(COEF_W-1){1'b0}}}));
    c.alpha = 21'sd1; c.beta = -21'sd3; c.gamma = 21'sd3;
    c.delta = 21'sd1; c.epsilon = 21'sd0; c.zeta = -21'sd1;
    send_item(c);
  endtask

  // degenerate prime, modulus and term count settings
  task automatic test_special_cases();
    coef_set_t c;
    c = same_coefs(21'sd5);
    set_regs(8'd0, prime_power(5, 20), 8'd5);
    send_item(c);
    write_reg(CFG_PRIME, 64'd1);
    send_item(c);
    write_reg(CFG_PRIME, 64'd4);
    send_item(c);
    write_reg(CFG_PRIME, 64'h1FF);
    send_item(c);
    set_regs(8'd2, 64'd0, 8'd5);
    send_item(c);
    write_reg(CFG_MODULUS, 64'd1);
    send_item(c);
    write_reg(CFG_MODULUS, 64'd2);
    send_item(c);
    write_reg(CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(c);
    write_reg(CFG_MODULUS, 64'h8000_0000_0000_0000);
    write_reg(CFG_TERMS, 64'd0);
    send_item(c);
    write_reg(CFG_TERMS, 64'd1);
    send_item(c);
    write_reg(CFG_TERMS, 64'd2);
    send_item(c);
    write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(c);
    set_regs(8'd251, prime_power(251, 8), 8'd255);
    send_item(rand_coefs());
    write_reg(CFG_TERMS, 64'd254);
    send_item(same_coefs('0));
  endtask

  // random candidates over random prime and modulus settings, mostly prime powers
  task automatic test_random(int idle, int stall, int count);
    int unsigned p;
    int unsigned primes[6] = '{2, 3, 5, 7, 13, 251};
    idle_pct = idle;
    stall_pct = stall;
    p = ($urandom_range(5) == 0) ? $urandom_range(255) : primes[$urandom_range(5)];
    set_regs(8'(p), ($urandom_range(9) == 0) ? {$urandom, $urandom} :
             prime_power(p, $urandom_range(64, 2)), 8'($urandom_range(6, 2)));
    for (int i = 0; i < count; i++) begin
      send_item(rand_coefs());
      if (i == count / 2) wait_drain();
    end
    wait_drain();
  endtask

  // receiver stalls
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_passes.size() == 0) begin
        $display("%0t: unexpected result passes=%0b", $time, out_ch.passes);
        failures++;
      end else begin
        if (out_ch.passes !== expected_passes[0]) begin
          $display("%0t: passes mismatch expected %0b actual %0b", $time,
                   expected_passes[0], out_ch.passes);
          failures++;
        end
        void'(expected_passes.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("recurrence_padic_integrality_test test failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.alpha   <= '0;
    in_ch.beta    <= '0;
    in_ch.gamma   <= '0;
    in_ch.delta   <= '0;
    in_ch.epsilon <= '0;
    in_ch.zeta    <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_special_cases();
    test_random(0, 0, 25);
    test_random(60, 0, 25);
    test_random(0, 60, 25);
    test_random(13, 13, 25);
    wait_drain();
    repeat (100) @(posedge clk);
    if (failures == 0)
      $display("recurrence_padic_integrality_test test passed");
    else
      $display("recurrence_padic_integrality_test test failed");
    $finish;
  end

endmodule
